[hw/rtl/lgs_pkg.sv]
// Shared types and constants for the linear gradient shader.
// No dependencies; used by lgs_cfg_if, lgs_lerp_div and linear_gradient_shader.
package lgs_pkg;

	localparam int CFG_DW = 26;
	localparam int OFF_W  = 17;
	localparam logic [OFF_W-1:0] ONE_Q16 = 17'h10000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_DIRECTION_MODE = 3'd0,
		CFG_IMAGE_WIDTH    = 3'd1,
		CFG_IMAGE_HEIGHT   = 3'd2,
		CFG_STOP_COUNT     = 3'd3,
		CFG_DIR_COS        = 3'd4,
		CFG_DIR_SIN        = 3'd5,
		CFG_INV_HALF_DIAG  = 3'd6
	} cfg_idx_t;

	// Direction modes; every other code yields position zero
	localparam logic [2:0] MODE_DOWN  = 3'd0;
	localparam logic [2:0] MODE_UP    = 3'd1;
	localparam logic [2:0] MODE_RIGHT = 3'd2;
	localparam logic [2:0] MODE_LEFT  = 3'd3;
	localparam logic [2:0] MODE_ANGLE = 3'd4;

	// Input item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_SHADE = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [3:0][7:0]  rgba;  // [0] red .. [3] alpha
	} stop_t;

	typedef struct packed {
		logic blank;  // no stops in use: output zero
		logic pass;   // degenerate pair: output the low stop's channel
	} lerp_ctl_t;

endpackage

[hw/rtl/lgs_in_if.sv]
// Input channel of the shader: stop loads and pixel requests.
// No dependencies.
interface lgs_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  stop_index;
	logic [7:0]  stop_red;
	logic [7:0]  stop_green;
	logic [7:0]  stop_blue;
	logic [7:0]  stop_alpha;
	logic [16:0] stop_offset;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;

	modport source(output valid, kind, stop_index, stop_red, stop_green, stop_blue,
		stop_alpha, stop_offset, pixel_x, pixel_y, input ready);
	modport sink(input valid, kind, stop_index, stop_red, stop_green, stop_blue,
		stop_alpha, stop_offset, pixel_x, pixel_y, output ready);
endinterface

[hw/rtl/lgs_out_if.sv]
// Output channel of the shader: one RGBA color per shaded pixel.
// No dependencies.
interface lgs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source(output valid, red, green, blue, alpha, input ready);
	modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

[hw/rtl/lgs_cfg_if.sv]
// Configuration write channel of the shader.
// Depends on lgs_pkg for the data width.
interface lgs_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [2:0]                index;
	logic [lgs_pkg::CFG_DW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/lgs_lerp_div.sv]
// One color channel of the interpolation: numerator sum, then an 8-bit
// restoring divide over two stages. Depends on lgs_pkg.
module lgs_lerp_div (
	input  logic                    clk,
	input  logic                    en,
	input  lgs_pkg::lerp_ctl_t      ctl,
	input  logic [7:0]              cl,
	input  logic [lgs_pkg::OFF_W-1:0] rng,
	input  logic [24:0]             p1,
	input  logic signed [26:0]      p2,
	output logic [7:0]              color
);
	logic signed [27:0] num;
	logic               zero_c, sat_c;

	lgs_pkg::lerp_ctl_t           ctl_s9, ctl_s10;
	logic                         zero_s9, sat_s9, zero_s10, sat_s10;
	logic [7:0]                   cl_s9, cl_s10;
	logic [lgs_pkg::OFF_W-1:0]    rng_s9, rng_s10;
	logic [24:0]                  rem_s9, rem_s10, rem_n10;
	logic [3:0]                   qh_s10, qh_n10;
	logic [3:0]                   ql_n11;
	logic [24:0]                  rem_n11;

	assign num    = $signed({3'b000, p1}) + $signed({p2[26], p2});
	assign zero_c = num[27];
	assign sat_c  = num >= $signed({3'b000, rng, 8'h00});

	// quotient bits 7..4
	always_comb begin
		logic [24:0] sh;
		rem_n10 = rem_s9;
		qh_n10  = '0;
		for (int k = 3; k >= 0; k--) begin
			sh = {8'h00, rng_s9} << (k + 4);
			if (rem_n10 >= sh) begin
				rem_n10   = rem_n10 - sh;
				qh_n10[k] = 1'b1;
			end
		end
	end

	// quotient bits 3..0
	always_comb begin
		logic [24:0] sh;
		rem_n11 = rem_s10;
		ql_n11  = '0;
		for (int k = 3; k >= 0; k--) begin
			sh = {8'h00, rng_s10} << k;
			if (rem_n11 >= sh) begin
				rem_n11   = rem_n11 - sh;
				ql_n11[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s9   <= ctl;
			zero_s9  <= zero_c;
			sat_s9   <= sat_c;
			cl_s9    <= cl;
			rng_s9   <= rng;
			rem_s9   <= num[24:0];
			ctl_s10  <= ctl_s9;
			zero_s10 <= zero_s9;
			sat_s10  <= sat_s9;
			cl_s10   <= cl_s9;
			rng_s10  <= rng_s9;
			rem_s10  <= rem_n10;
			qh_s10   <= qh_n10;
			priority if (ctl_s10.blank) color <= 8'h00;
			else if (ctl_s10.pass)      color <= cl_s10;
			else if (zero_s10)          color <= 8'h00;
			else if (sat_s10)           color <= 8'hFF;
			else                        color <= {qh_s10, ql_n11};
		end
	end
endmodule

[hw/rtl/linear_gradient_shader.sv]
// Linear gradient shader top level: configuration, position pipeline,
// stop table and search. Depends on lgs_pkg, the lgs_*_if interfaces and lgs_lerp_div.
//
//  channel   dir  handshake     carries
//  cfg       in   valid/ready   index, data (register write)
//  pix_in    in   valid/ready   kind, stop load fields, pixel_x, pixel_y
//  pix_out   out  valid/ready   red, green, blue, alpha
//
// One item enters per clock unless pix_out stalls; a shaded pixel leaves from the
// output register, stage 11. The pipeline holds the 16-step axis divide (stages 2-5),
// the stop search and table read (6-7), the products (8) and the channel divide (9-11).
// Loads write the table as they leave stage 5, keeping order with pixels.
// Reset clears configuration and valid bits; the stop table is not cleared.
// A stall on pix_out freezes every stage; nothing is dropped or repeated.
module linear_gradient_shader #(
	parameter int MAX_STOPS = 16,
	parameter int MAX_DIM   = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	lgs_cfg_if.sink       cfg,
	lgs_in_if.sink        pix_in,
	lgs_out_if.source     pix_out
);
	localparam int SIW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int NW  = $clog2(MAX_STOPS + 1);
	localparam int OW  = lgs_pkg::OFF_W;

	// ---------------- configuration registers ----------------
	logic [2:0]         mode_q;
	logic [12:0]        width_q, height_q;
	logic [4:0]         count_q;
	logic signed [15:0] cos_q, sin_q;
	logic [25:0]        inv_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 3'd0;
			width_q  <= 13'd1;
			height_q <= 13'd1;
			count_q  <= 5'd0;
			cos_q    <= 16'sd16384;
			sin_q    <= 16'sd0;
			inv_q    <= 26'd0;
		end else if (cfg.valid) begin
			unique case (lgs_pkg::cfg_idx_t'(cfg.index))
				lgs_pkg::CFG_DIRECTION_MODE: mode_q   <= cfg.data[2:0];
				lgs_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg.data[12:0];
				lgs_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg.data[12:0];
				lgs_pkg::CFG_STOP_COUNT:     count_q  <= cfg.data[4:0];
				lgs_pkg::CFG_DIR_COS:        cos_q    <= $signed(cfg.data[15:0]);
				lgs_pkg::CFG_DIR_SIN:        sin_q    <= $signed(cfg.data[15:0]);
				lgs_pkg::CFG_INV_HALF_DIAG:  inv_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Spans saturate to MAX_DIM; stop count saturates to MAX_STOPS
	logic [12:0]   w_sat, h_sat, span, d;
	logic [NW-1:0] n_sat;
	logic          vert;

	assign w_sat = (32'(width_q) > MAX_DIM) ? 13'(MAX_DIM) : width_q;
	assign h_sat = (32'(height_q) > MAX_DIM) ? 13'(MAX_DIM) : height_q;
	assign vert  = (mode_q == lgs_pkg::MODE_DOWN) || (mode_q == lgs_pkg::MODE_UP);
	assign span  = vert ? h_sat : w_sat;
	assign d     = span - 13'd1;
	assign n_sat = (32'(count_q) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(count_q);

	// ---------------- pipeline control ----------------
	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;

	// Hold everything while the output register is full and not taken
	assign advance      = !v_s11 || pix_out.ready;
	assign pix_in.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11}     <= '0;
		end else if (advance) begin
			v_s1  <= pix_in.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			// loads retire at stage 5; only pixels go on
			v_s6  <= v_s5 && (kind_s5 == lgs_pkg::KIND_SHADE);
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// ---------------- stage 1: capture, angle products, divide setup ----------------
	logic [11:0]        coord;
	logic signed [14:0] ex, ey;
	logic signed [30:0] pc, ps;

	assign coord = vert ? pix_in.pixel_y : pix_in.pixel_x;
	assign ex    = $signed({2'b00, pix_in.pixel_x, 1'b0}) - $signed({2'b00, w_sat});
	assign ey    = $signed({2'b00, pix_in.pixel_y, 1'b0}) - $signed({2'b00, h_sat});
	assign pc    = ex * cos_q;
	assign ps    = ey * sin_q;

	logic [3:0]          idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	lgs_pkg::stop_t      ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic signed [30:0]  pc_s1, ps_s1;
	logic                zero_s1, zero_s2, zero_s3, zero_s4;
	logic                big_s1, big_s2, big_s3, big_s4;
	logic [12:0]         rem_s1, rem_s2, rem_s3, rem_s4;
	logic [15:0]         quo_s2, quo_s3, quo_s4;
	logic signed [31:0]  p_s2;
	logic signed [58:0]  mul_s3;
	logic [OW-1:0]       ang_s4;
	logic [OW-1:0]       pos_s5;

	// Four steps of the restoring divide (coord << 16) / (span - 1)
	function automatic logic [28:0] axis_steps(input logic [12:0] r, input logic [15:0] q,
		input logic [12:0] dv);
		logic [13:0] r2;
		logic [12:0] rr;
		logic [15:0] qq;
		rr = r;
		qq = q;
		for (int k = 0; k < 4; k++) begin
			r2 = {rr, 1'b0};
			if (r2 >= {1'b0, dv}) begin
				rr = 13'(r2 - {1'b0, dv});
				qq = {qq[14:0], 1'b1};
			end else begin
				rr = r2[12:0];
				qq = {qq[14:0], 1'b0};
			end
		end
		return {rr, qq};
	endfunction

	logic [28:0]        dv2, dv3, dv4, dv5;
	logic signed [59:0] ang_sum;
	logic [OW-1:0]      ang_n4, axis_n5, pos_n5;

	assign dv2 = axis_steps(rem_s1, 16'h0000, d);
	assign dv3 = axis_steps(rem_s2, quo_s2, d);
	assign dv4 = axis_steps(rem_s3, quo_s3, d);
	assign dv5 = axis_steps(rem_s4, quo_s4, d);

	// Round to half and drop the Q1.24 scale, then clamp to [0, one]
	assign ang_sum = $signed({mul_s3[58], mul_s3}) + 60'sh0_0080_0000_0000;
	always_comb begin
		if (ang_sum[59])                        ang_n4 = '0;
		else if (ang_sum[58:24] > 35'd65536)    ang_n4 = lgs_pkg::ONE_Q16;
		else                                    ang_n4 = ang_sum[40:24];
	end

	always_comb begin
		priority if (zero_s4) axis_n5 = '0;
		else if (big_s4)      axis_n5 = lgs_pkg::ONE_Q16;
		else                  axis_n5 = {1'b0, dv5[15:0]};
		unique case (mode_q)
			lgs_pkg::MODE_DOWN, lgs_pkg::MODE_RIGHT: pos_n5 = axis_n5;
			lgs_pkg::MODE_UP, lgs_pkg::MODE_LEFT:    pos_n5 = lgs_pkg::ONE_Q16 - axis_n5;
			lgs_pkg::MODE_ANGLE:                     pos_n5 = ang_s4;
			default:                                 pos_n5 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1   <= pix_in.kind;
			idx_s1    <= pix_in.stop_index;
			ld_s1     <= {pix_in.stop_offset, pix_in.stop_alpha, pix_in.stop_blue,
				pix_in.stop_green, pix_in.stop_red};
			pc_s1     <= pc;
			ps_s1     <= ps;
			zero_s1   <= span <= 13'd1;
			big_s1    <= {1'b0, coord} >= d;
			rem_s1    <= {1'b0, coord};
			// stage 2
			kind_s2   <= kind_s1;
			idx_s2    <= idx_s1;
			ld_s2     <= ld_s1;
			zero_s2   <= zero_s1;
			big_s2    <= big_s1;
			{rem_s2, quo_s2} <= dv2;
			p_s2      <= $signed({pc_s1[30], pc_s1}) + $signed({ps_s1[30], ps_s1});
			// stage 3
			kind_s3   <= kind_s2;
			idx_s3    <= idx_s2;
			ld_s3     <= ld_s2;
			zero_s3   <= zero_s2;
			big_s3    <= big_s2;
			{rem_s3, quo_s3} <= dv3;
			mul_s3    <= p_s2 * $signed({1'b0, inv_q});
			// stage 4
			kind_s4   <= kind_s3;
			idx_s4    <= idx_s3;
			ld_s4     <= ld_s3;
			zero_s4   <= zero_s3;
			big_s4    <= big_s3;
			{rem_s4, quo_s4} <= dv4;
			ang_s4    <= ang_n4;
			// stage 5
			kind_s5   <= kind_s4;
			idx_s5    <= idx_s4;
			ld_s5     <= ld_s4;
			pos_s5    <= pos_n5;
		end
	end

	// ---------------- stop table ----------------
	// Offsets live in flops for the parallel compare; full entries in a
	// two-read memory for the pair fetch.
	logic [OW-1:0]  off_q [MAX_STOPS];
	lgs_pkg::stop_t stop_mem [MAX_STOPS];
	logic           tbl_we;

	assign tbl_we = advance && v_s5 && (kind_s5 == lgs_pkg::KIND_LOAD) &&
		(32'(idx_s5) < MAX_STOPS);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			off_q[SIW'(idx_s5)]    <= ld_s5.off;
			stop_mem[SIW'(idx_s5)] <= ld_s5;
		end
	end

	// ---------------- stage 6: bracket search ----------------
	logic [SIW-1:0] lo_n6, hi_n6, lo_s6, hi_s6;
	logic           found;
	logic [OW-1:0]  pos_s6, pos_s7;
	logic           n0_s6, n0_s7, same_s6, same_s7;

	always_comb begin
		lo_n6 = '0;
		found = 1'b0;
		// scan downward so the first bracketing pair wins
		for (int i = MAX_STOPS - 2; i >= 0; i--) begin
			if ((32'(i + 1) < 32'(n_sat)) && (pos_s5 >= off_q[i]) && (pos_s5 <= off_q[i + 1])) begin
				lo_n6 = SIW'(i);
				found = 1'b1;
			end
		end
		if (found)             hi_n6 = lo_n6 + SIW'(1);
		else if (n_sat != '0)  hi_n6 = SIW'(n_sat - NW'(1));
		else                   hi_n6 = '0;
	end

	lgs_pkg::stop_t lo_ent_s7, hi_ent_s7;

	always_ff @(posedge clk) begin
		if (advance) begin
			lo_s6     <= lo_n6;
			hi_s6     <= hi_n6;
			pos_s6    <= pos_s5;
			n0_s6     <= n_sat == '0;
			same_s6   <= lo_n6 == hi_n6;
			// stage 7: table read
			lo_ent_s7 <= stop_mem[lo_s6];
			hi_ent_s7 <= stop_mem[hi_s6];
			pos_s7    <= pos_s6;
			n0_s7     <= n0_s6;
			same_s7   <= same_s6;
		end
	end

	// ---------------- stage 8: interpolation products ----------------
	logic signed [17:0] range, dpos;
	lgs_pkg::lerp_ctl_t ctl_n8, ctl_s8;
	logic [OW-1:0]      rng_s8;
	logic [7:0]         cl_s8 [4];
	logic [24:0]        p1_s8 [4];
	logic signed [26:0] p2_s8 [4];
	logic [7:0]         chan [4];

	assign range        = $signed({1'b0, hi_ent_s7.off}) - $signed({1'b0, lo_ent_s7.off});
	assign dpos         = $signed({1'b0, pos_s7}) - $signed({1'b0, lo_ent_s7.off});
	assign ctl_n8.blank = n0_s7;
	assign ctl_n8.pass  = same_s7 || (range <= 18'sd0);

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s8 <= ctl_n8;
			rng_s8 <= range[OW-1:0];
			for (int c = 0; c < 4; c++) begin
				cl_s8[c] <= lo_ent_s7.rgba[c];
				p1_s8[c] <= lo_ent_s7.rgba[c] * range[OW-1:0];
				p2_s8[c] <= ($signed({1'b0, hi_ent_s7.rgba[c]}) -
					$signed({1'b0, lo_ent_s7.rgba[c]})) * dpos;
			end
		end
	end

	// ---------------- stages 9-11: per-channel divide ----------------
	for (genvar c = 0; c < 4; c++) begin : g_chan
		lgs_lerp_div u_div (
			.clk   (clk),
			.en    (advance),
			.ctl   (ctl_s8),
			.cl    (cl_s8[c]),
			.rng   (rng_s8),
			.p1    (p1_s8[c]),
			.p2    (p2_s8[c]),
			.color (chan[c])
		);
	end

	assign pix_out.valid = v_s11;
	assign pix_out.red   = chan[0];
	assign pix_out.green = chan[1];
	assign pix_out.blue  = chan[2];
	assign pix_out.alpha = chan[3];

	// ---------------- assertions ----------------
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> pix_out.valid)
		else $error("input stalled with an empty output register");

	a_tail_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && advance) |=> v_s11)
		else $error("pixel lost between stage 10 and the output register");

	a_pair_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !n0_s6) |-> (lo_s6 <= hi_s6))
		else $error("stop pair out of order");
endmodule
